// ===== hw/rtl/mbsr_pkg.sv =====
// mbsr_pkg: shared types, constants and the crc helper for the modbus sensor read block
// no dependencies; imported by the interfaces and every rtl module
package mbsr_pkg;

    // crc16 modbus (reflected polynomial)
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // protocol constants
    localparam logic [7:0] FN_READ       = 8'h03;
    localparam int         FN_EXC_BIT    = 7;
    localparam logic [7:0] REG_COUNT_HI  = 8'h00;
    localparam logic [7:0] REG_COUNT_LO  = 8'h02;
    localparam logic [7:0] RESP_BYTE_CNT = 8'h04;
    localparam logic [3:0] RESP_LEN      = 4'd9;
    localparam logic [2:0] TX_CRC_FIRST  = 3'd6;
    localparam logic [2:0] TX_LAST_IDX   = 3'd7;

    // register reset values
    localparam logic [7:0]  ADDR_RST    = 8'd15;
    localparam logic [15:0] START_RST   = 16'h0300;
    localparam logic [15:0] TIMEOUT_RST = 16'd200;

    typedef enum logic [1:0] {
        CFG_ADDR    = 2'd0,
        CFG_START   = 2'd1,
        CFG_TIMEOUT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_BYTE  = 2'd1,
        REQ_TICK  = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TIMEOUT  = 3'd1,
        ST_BAD_CRC  = 3'd2,
        ST_BAD_ADDR = 3'd3,
        ST_EXC      = 3'd4,
        ST_BAD_FN   = 3'd5,
        ST_BAD_CNT  = 3'd6,
        ST_ZERO     = 3'd7
    } t_status;

    // one outgoing beat
    typedef struct packed {
        logic               kind;
        logic [7:0]         tx_byte;
        logic               last;
        t_status            status;
        logic [7:0]         exception_code;
        logic signed [15:0] temperature;
        logic [15:0]        humidity;
        logic [3:0]         bytes_received;
    } t_result;

    // item handed from the input register to the receive engine
    typedef struct packed {
        logic       go;
        t_req       req;
        logic [7:0] rx_byte;
    } t_rx_item;

    // one byte of crc16, unrolled over its eight bits
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/mbsr_in_if.sv =====
// mbsr_in_if: valid/ready channel carrying request items into the block
// depends on mbsr_pkg
interface mbsr_in_if
    import mbsr_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

// ===== hw/rtl/mbsr_out_if.sv =====
// mbsr_out_if: valid/ready channel carrying request bytes and results out of the block
// depends on mbsr_pkg
interface mbsr_out_if
    import mbsr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [7:0]         tx_byte;
    logic               last;
    logic [2:0]         status;
    logic [7:0]         exception_code;
    logic signed [15:0] temperature;
    logic [15:0]        humidity;
    logic [3:0]         bytes_received;

    modport source (output valid, output kind, output tx_byte, output last, output status,
                    output exception_code, output temperature, output humidity,
                    output bytes_received, input ready);
    modport sink   (input valid, input kind, input tx_byte, input last, input status,
                    input exception_code, input temperature, input humidity,
                    input bytes_received, output ready);
endinterface

// ===== hw/rtl/mbsr_tx_frame.sv =====
// mbsr_tx_frame: sequencer for the 8-byte read request frame, crc built one byte per beat
// depends on mbsr_pkg
module mbsr_tx_frame
    import mbsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_advance,
    input  logic [7:0]  i_addr,
    input  logic [15:0] i_start_reg,
    output logic        o_active,
    output t_result     o_beat
);

    logic        r_active, n_active;
    logic [2:0]  r_idx, n_idx;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  tx_byte;

    always_comb begin
        unique case (r_idx)
            3'd0:    tx_byte = i_addr;
            3'd1:    tx_byte = FN_READ;
            3'd2:    tx_byte = i_start_reg[15:8];
            3'd3:    tx_byte = i_start_reg[7:0];
            3'd4:    tx_byte = REG_COUNT_HI;
            3'd5:    tx_byte = REG_COUNT_LO;
            3'd6:    tx_byte = r_crc[7:0];
            default: tx_byte = r_crc[15:8];
        endcase
    end

    always_comb begin
        n_active = r_active;
        n_idx    = r_idx;
        n_crc    = r_crc;
        if (i_start) begin
            n_active = 1'b1;
            n_idx    = 3'd0;
            n_crc    = CRC_INIT;
        end else if (i_advance && r_active) begin
            n_idx = r_idx + 3'd1;
            if (r_idx < TX_CRC_FIRST) begin
                n_crc = crc_byte(r_crc, tx_byte);
            end
            if (r_idx == TX_LAST_IDX) begin
                n_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= 3'd0;
            r_crc    <= CRC_INIT;
        end else begin
            r_active <= n_active;
            r_idx    <= n_idx;
            r_crc    <= n_crc;
        end
    end

    always_comb begin
        o_beat         = '0;
        o_beat.kind    = 1'b0;
        o_beat.tx_byte = tx_byte;
        o_beat.last    = (r_idx == TX_LAST_IDX);
        o_beat.status  = ST_OK;
    end

    assign o_active = r_active;

endmodule

// ===== hw/rtl/mbsr_rx_engine.sv =====
// mbsr_rx_engine: response collection, tick timeout and frame checks
// depends on mbsr_pkg
module mbsr_rx_engine
    import mbsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_rx_item    i_item,
    input  logic [7:0]  i_addr,
    input  logic [15:0] i_timeout,
    output logic        o_res_valid,
    output t_result     o_res
);

    logic        r_collecting, n_collecting;
    logic [3:0]  r_count, n_count;
    logic [15:0] r_elapsed, n_elapsed;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_store [8];

    logic        byte_go;
    t_status     fin_status;
    logic [7:0]  fin_exc;
    logic [15:0] fin_temp;
    logic [15:0] fin_hum;

    assign byte_go = i_item.go && (i_item.req == REQ_BYTE) && r_collecting;

    // checks of a complete frame; the ninth byte is the one arriving now
    always_comb begin
        fin_temp = {r_store[3], r_store[4]};
        fin_hum  = {r_store[5], r_store[6]};
        fin_exc  = 8'h00;
        priority if ({i_item.rx_byte, r_store[7]} != r_crc) begin
            fin_status = ST_BAD_CRC;
        end else if (r_store[0] != i_addr) begin
            fin_status = ST_BAD_ADDR;
        end else if (r_store[1] != FN_READ) begin
            if (r_store[1][FN_EXC_BIT]) begin
                fin_status = ST_EXC;
                fin_exc    = r_store[2];
            end else begin
                fin_status = ST_BAD_FN;
            end
        end else if (r_store[2] != RESP_BYTE_CNT) begin
            fin_status = ST_BAD_CNT;
        end else if (fin_temp == 16'h0000 && fin_hum == 16'h0000) begin
            fin_status = ST_ZERO;
        end else begin
            fin_status = ST_OK;
        end
    end

    always_comb begin
        n_collecting = r_collecting;
        n_count      = r_count;
        n_elapsed    = r_elapsed;
        n_crc        = r_crc;
        o_res_valid  = 1'b0;
        o_res        = '0;
        o_res.kind   = 1'b1;
        o_res.status = ST_OK;
        if (i_item.go) begin
            unique case (i_item.req)
                REQ_START: begin
                    n_collecting = 1'b1;
                    n_count      = 4'd0;
                    n_elapsed    = 16'd0;
                    n_crc        = CRC_INIT;
                end
                REQ_BYTE: begin
                    if (r_collecting) begin
                        if (r_count < 4'd7) begin
                            n_crc = crc_byte(r_crc, i_item.rx_byte);
                        end
                        n_count = r_count + 4'd1;
                        if (r_count == RESP_LEN - 4'd1) begin
                            n_collecting         = 1'b0;
                            o_res_valid          = 1'b1;
                            o_res.status         = fin_status;
                            o_res.exception_code = fin_exc;
                            o_res.bytes_received = RESP_LEN;
                            if (fin_status == ST_OK || fin_status == ST_ZERO) begin
                                o_res.temperature = $signed(fin_temp);
                                o_res.humidity    = fin_hum;
                            end
                        end
                    end
                end
                REQ_TICK: begin
                    if (r_collecting) begin
                        if (r_elapsed != 16'hFFFF) begin
                            n_elapsed = r_elapsed + 16'd1;
                        end
                        if (n_elapsed >= i_timeout) begin
                            n_collecting         = 1'b0;
                            o_res_valid          = 1'b1;
                            o_res.status         = ST_TIMEOUT;
                            o_res.bytes_received = r_count;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting <= 1'b0;
            r_count      <= 4'd0;
            r_elapsed    <= 16'd0;
            r_crc        <= CRC_INIT;
        end else begin
            r_collecting <= n_collecting;
            r_count      <= n_count;
            r_elapsed    <= n_elapsed;
            r_crc        <= n_crc;
        end
    end

    // bytes 0..7 are kept, the ninth is checked on arrival
    always_ff @(posedge i_clk) begin
        if (byte_go && !r_count[3]) begin
            r_store[r_count[2:0]] <= i_item.rx_byte;
        end
    end

endmodule

// ===== hw/rtl/modbus_sensor_read_transaction_top.sv =====
// modbus_sensor_read_transaction_top: top level of the modbus rtu sensor read block
// depends on mbsr_pkg, mbsr_in_if, mbsr_out_if, mbsr_tx_frame, mbsr_rx_engine
//
// A start item emits the 8-byte function 3 read request (address, 0x03, start register,
// count 2, crc16 low byte first) as eight kind 0 beats, the eighth marked last, and opens
// reception. Received bytes and millisecond ticks are taken while a transaction is open:
// the ninth response byte yields one result beat with the checked status, raw signed
// temperature and humidity, and reaching the tick limit yields a timeout beat with the
// partial byte count. Bytes and ticks while idle, and request code 3, give no beat.
// Each item passes an input register and is worked on combinationally into the output
// register, so byte, tick and ignored items flow at one per cycle while the output is not
// stalled. After a start item the next item waits in the input register while the frame
// sequencer sends the eight request beats, one per cycle unless the output stalls them.
// Configuration is a plain write port: index 0 address, 1 start register, 2 timeout ticks;
// other indexes ignored.
module modbus_sensor_read_transaction_top
    import mbsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    mbsr_in_if.sink     i_req,
    mbsr_out_if.source  o_res
);

    // configuration registers
    logic [7:0]  r_addr;
    logic [15:0] r_start_reg;
    logic [15:0] r_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= ADDR_RST;
            r_start_reg <= START_RST;
            r_timeout   <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ADDR:    r_addr      <= i_cfg_data[7:0];
                CFG_START:   r_start_reg <= i_cfg_data;
                CFG_TIMEOUT: r_timeout   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    logic       r_in_valid;
    t_req       r_in_req;
    logic [7:0] r_in_byte;

    // output register
    logic       r_out_valid;
    t_result    r_out;

    logic       out_free;
    logic       tx_active;
    logic       emit_tx;
    logic       proc;
    t_result    tx_beat;
    t_rx_item   rx_item;
    logic       rx_res_valid;
    t_result    rx_res;

    // output slot can be loaded this cycle
    assign out_free = !r_out_valid || o_res.ready;
    // request frame beats have priority; the held item waits for the frame to finish
    assign emit_tx  = tx_active && out_free;
    assign proc     = r_in_valid && !tx_active && out_free;

    assign i_req.ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_req  <= t_req'(i_req.req_type);
            r_in_byte <= i_req.rx_byte;
        end
    end

    always_comb begin
        rx_item.go      = proc;
        rx_item.req     = r_in_req;
        rx_item.rx_byte = r_in_byte;
    end

    mbsr_tx_frame u_tx_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (proc && (r_in_req == REQ_START)),
        .i_advance   (emit_tx),
        .i_addr      (r_addr),
        .i_start_reg (r_start_reg),
        .o_active    (tx_active),
        .o_beat      (tx_beat)
    );

    mbsr_rx_engine u_rx_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (rx_item),
        .i_addr      (r_addr),
        .i_timeout   (r_timeout),
        .o_res_valid (rx_res_valid),
        .o_res       (rx_res)
    );

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_tx || (proc && rx_res_valid)) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_tx) begin
            r_out <= tx_beat;
        end else if (proc && rx_res_valid) begin
            r_out <= rx_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.kind           = r_out.kind;
    assign o_res.tx_byte        = r_out.tx_byte;
    assign o_res.last           = r_out.last;
    assign o_res.status         = r_out.status;
    assign o_res.exception_code = r_out.exception_code;
    assign o_res.temperature    = r_out.temperature;
    assign o_res.humidity       = r_out.humidity;
    assign o_res.bytes_received = r_out.bytes_received;

endmodule
